// ===== hdl/bkl_pkg.sv =====
// Shared types and constants for the bakery ticket lock arbiter.
package bkl_pkg;

  localparam int REQUESTERS  = 10;
  localparam int TICKET_BITS = 8;

  localparam int IDX_W   = $clog2(REQUESTERS);
  localparam int REQ_W   = 4;
  localparam int GIVEN_W = 8;
  localparam int CMP_W   = (IDX_W > REQ_W) ? IDX_W : REQ_W;
  localparam int EXT_W   = (TICKET_BITS > GIVEN_W) ? TICKET_BITS : GIVEN_W;

  localparam logic [IDX_W-1:0]       IDX_LAST   = IDX_W'(REQUESTERS - 1);
  localparam logic [CMP_W-1:0]       REQ_LIMIT  = CMP_W'(REQUESTERS);
  localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

  typedef logic [TICKET_BITS-1:0] ticket_t;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_SAT  = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } bkl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } bkl_sts_t;

endpackage

// ===== hdl/bkl_ctrl.sv =====
// Sequencer for the ticket scan: accept, scan the table, commit and load output.
module bkl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bkl_pkg::bkl_sts_t sts,
  output bkl_pkg::bkl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.out_busy)
    else $error("commit while output word still pending");

  a_load_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_SCAN))
    else $error("accepted word did not start a scan");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("more than one command at once");

endmodule

// ===== hdl/bkl_dp.sv =====
// Ticket table, one-comparator scan and output register.
module bkl_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  bkl_pkg::bkl_cmd_t           cmd,
  output bkl_pkg::bkl_sts_t           sts,
  input  logic                        op_in,
  input  logic [bkl_pkg::REQ_W-1:0]   req_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [bkl_pkg::GIVEN_W-1:0] ticket_given,
  output logic                        lock_held,
  output logic [bkl_pkg::REQ_W-1:0]   holder
);

  bkl_pkg::ticket_t tickets [bkl_pkg::REQUESTERS];

  logic                       op;
  logic [bkl_pkg::CMP_W-1:0]  req;
  logic [bkl_pkg::IDX_W-1:0]  idx;
  bkl_pkg::ticket_t           max_t;
  bkl_pkg::ticket_t           own_t;
  bkl_pkg::ticket_t           min_t;
  logic [bkl_pkg::IDX_W-1:0]  min_idx;
  logic                       min_found;

  bkl_pkg::ticket_t           rd;
  logic [bkl_pkg::CMP_W-1:0]  idx_cmp;
  logic [bkl_pkg::IDX_W-1:0]  req_idx;
  logic                       in_range;
  logic                       own_wins;
  logic                       all_found;
  logic [bkl_pkg::IDX_W-1:0]  all_idx;
  bkl_pkg::ticket_t           next_t;
  logic [bkl_pkg::EXT_W-1:0]  next_ext;

  logic                       wr_en;
  bkl_pkg::ticket_t           wr_val;
  bkl_pkg::status_t           st_c;
  logic [bkl_pkg::GIVEN_W-1:0] given_c;
  logic                       held_c;
  logic [bkl_pkg::IDX_W-1:0]  holder_c;

  assign rd       = tickets[idx];
  assign idx_cmp  = bkl_pkg::CMP_W'(idx);
  assign req_idx  = req[bkl_pkg::IDX_W-1:0];
  assign in_range = (req < bkl_pkg::REQ_LIMIT);
  assign next_t   = max_t + bkl_pkg::TICKET_BITS'(1);
  assign next_ext = bkl_pkg::EXT_W'(next_t);

  assign sts = '{scan_last: (idx == bkl_pkg::IDX_LAST),
                 out_busy:  (out_valid && !out_ready)};

  // fold the requester's own ticket into the minimum over the others
  always_comb begin
    own_wins = (own_t != '0) &&
               (!min_found || (own_t < min_t) || ((own_t == min_t) && (req_idx < min_idx)));
    all_found = min_found || (own_t != '0);
    all_idx   = own_wins ? req_idx : min_idx;
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_val   = '0;
    st_c     = bkl_pkg::ST_OK;
    given_c  = '0;
    held_c   = all_found;
    holder_c = all_idx;
    if (!in_range) begin
      st_c = bkl_pkg::ST_NONE;
    end else if (op == bkl_pkg::OP_ACQUIRE) begin
      if (own_t != '0) begin
        st_c = bkl_pkg::ST_DUP;
      end else if (max_t == bkl_pkg::TICKET_MAX) begin
        st_c = bkl_pkg::ST_SAT;
      end else begin
        wr_en    = 1'b1;
        wr_val   = next_t;
        given_c  = next_ext[bkl_pkg::GIVEN_W-1:0];
        held_c   = 1'b1;
        holder_c = min_found ? min_idx : req_idx;
      end
    end else begin
      if (own_t == '0) begin
        st_c = bkl_pkg::ST_NONE;
      end else begin
        wr_en    = 1'b1;
        wr_val   = '0;
        held_c   = min_found;
        holder_c = min_found ? min_idx : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bkl_pkg::REQUESTERS; i++) begin
        tickets[i] <= '0;
      end
    end else if (cmd.finish && wr_en) begin
      tickets[req_idx] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= op_in;
      req       <= bkl_pkg::CMP_W'(req_in);
      idx       <= '0;
      max_t     <= '0;
      own_t     <= '0;
      min_t     <= '0;
      min_idx   <= '0;
      min_found <= 1'b0;
    end else if (cmd.step) begin
      if (rd > max_t) begin
        max_t <= rd;
      end
      if (idx_cmp == req) begin
        own_t <= rd;
      end else if ((rd != '0) && (!min_found || (rd < min_t))) begin
        min_t     <= rd;
        min_idx   <= idx;
        min_found <= 1'b1;
      end
      if (!sts.scan_last) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status       <= st_c;
      ticket_given <= given_c;
      lock_held    <= held_c;
      holder       <= held_c ? bkl_pkg::REQ_W'(holder_c) : '0;
    end
  end

  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("commit did not present an output word");

  a_idle_holder: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !lock_held) |-> (holder == '0))
    else $error("holder reported with no ticket held");

  a_given_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != bkl_pkg::ST_OK)) |-> (ticket_given == '0))
    else $error("ticket given on a failed operation");

endmodule

// ===== hdl/bakery_ticket_lock_arbiter_unit.sv =====
// Top level of the bakery ticket lock arbiter: stream ports around control and datapath.
// The result word is registered in the commit state after the table scan; commit stalls while
// the previous result is still pending at the output register. The single-comparator table scan
// reads one table entry per cycle, and a new input word is accepted only in idle, after commit.
// The next input word is taken while the previous result still waits at the output register.
// Reset (rst, synchronous): clears every ticket to zero, drops m_tvalid, returns to idle.
module bakery_ticket_lock_arbiter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] operation, [4:1] requester, [7:5] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [1:0] status, [9:2] ticket_given, [10] lock_held,
                                 // [14:11] holder, [15] zero
);

  bkl_pkg::bkl_cmd_t cmd;
  bkl_pkg::bkl_sts_t sts;

  logic [1:0]                  status;
  logic [bkl_pkg::GIVEN_W-1:0] ticket_given;
  logic                        lock_held;
  logic [bkl_pkg::REQ_W-1:0]   holder;

  bkl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bkl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op_in        (s_tdata[0]),
    .req_in       (s_tdata[4:1]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (status),
    .ticket_given (ticket_given),
    .lock_held    (lock_held),
    .holder       (holder)
  );

  assign m_tdata = {1'b0, holder, lock_held, ticket_given, status};

endmodule
